@@ design/thrift_compact_token_encoder_macros.svh @@
// Assertion macros for the compact token encoder.
`ifndef THRIFT_COMPACT_TOKEN_ENCODER_MACROS_SVH
`define THRIFT_COMPACT_TOKEN_ENCODER_MACROS_SVH

`ifndef SYNTHESIS
// Checked on clk_i, off while rst_ni is low.
`define TCTE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tcte assertion failed");
// Checked on clk_i, also during reset.
`define TCTE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("tcte assertion failed");
`else
`define TCTE_ASSERT(lbl, prop)
`define TCTE_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ design/tcte_pkg.sv @@
package tcte_pkg;

  localparam int unsigned CmdW      = 4;
  localparam int unsigned TypeW     = 4;
  localparam int unsigned IdW       = 16;
  localparam int unsigned SizeW     = 31;
  localparam int unsigned ValueW    = 64;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned MaxBytes  = 10;
  localparam int unsigned CntW      = $clog2(MaxBytes + 1);
  localparam int unsigned BufW      = MaxBytes * ByteW;
  localparam int unsigned GroupW    = 7;

  localparam logic [7:0] BoolTrue   = 8'h11;
  localparam logic [7:0] BoolFalse  = 8'h12;
  localparam logic [7:0] ShortField = 8'h10;
  localparam logic [7:0] LongList   = 8'hF0;
  localparam logic [3:0] ShortListMax = 4'd14;
  localparam logic [3:0] MaxTypeSel = 4'd10;

  typedef enum logic [CmdW-1:0] {
    CmdRaw     = 4'd0,
    CmdBool    = 4'd1,
    CmdShortFld = 4'd2,
    CmdField   = 4'd3,
    CmdList    = 4'd4,
    CmdI16     = 4'd5,
    CmdI32     = 4'd6,
    CmdI64     = 4'd7,
    CmdUvarint = 4'd8
  } tcte_cmd_e;

  function automatic logic [3:0] type_code(input logic [TypeW-1:0] sel);
    return (sel <= MaxTypeSel) ? 4'(sel + 4'd2) : 4'd0;
  endfunction

endpackage

@@ design/thrift_compact_token_encoder.sv @@
// Thrift compact-protocol token encoder.
// Input channel (in_valid_i/in_ready_o): one encode request per item, with
// cmd_i, type_sel_i, field_id_i, prev_id_i, list_size_i and value_i.
// Output channel (out_valid_o/out_ready_i): one encoded byte per item on
// out_byte_o, last_o high on the final byte of a request. Unknown commands
// produce no bytes.
// The first byte of a request is presented from the byte buffer once the
// request has passed the input register and been loaded there.
// Throughput: one byte per cycle while out_ready_i is high; a known command
// yields 1 to 10 bytes, and the next request is loaded into the byte buffer in
// the cycle its predecessor's last byte is taken, so bytes flow without gaps.
// A stalled receiver freezes the byte buffer; one further request waits in
// the input register, after which in_ready_o drops.
// Reset empties both the input register and the byte buffer.
`include "thrift_compact_token_encoder_macros.svh"

module thrift_compact_token_encoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [tcte_pkg::CmdW-1:0]         cmd_i,
  input  logic [tcte_pkg::TypeW-1:0]        type_sel_i,
  input  logic signed [tcte_pkg::IdW-1:0]   field_id_i,
  input  logic signed [tcte_pkg::IdW-1:0]   prev_id_i,
  input  logic [tcte_pkg::SizeW-1:0]        list_size_i,
  input  logic [tcte_pkg::ValueW-1:0]       value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [tcte_pkg::ByteW-1:0]        out_byte_o,
  output logic                              last_o
);
  import tcte_pkg::*;

  // input register
  logic              in_valid_q;
  logic [CmdW-1:0]   cmd_q;
  logic [TypeW-1:0]  type_sel_q;
  logic [IdW-1:0]    field_id_q;
  logic [IdW-1:0]    prev_id_q;
  logic [SizeW-1:0]  list_size_q;
  logic [ValueW-1:0] value_q;

  // byte buffer
  logic [BufW-1:0]   buf_q, buf_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  logic              load;
  logic              out_take;

  // encode
  logic [3:0]        tc;
  logic [IdW:0]      delta;
  logic              fld_short;
  logic              list_short;
  logic [ValueW-1:0] vsrc;
  logic [69:0]       vext;
  logic [GroupW-1:0] grp [MaxBytes];
  logic [CntW-1:0]   vcnt;
  logic [BufW-1:0]   vbytes;
  logic [BufW-1:0]   enc_bytes;
  logic [CntW-1:0]   enc_cnt;
  logic [IdW-1:0]    zz16;
  logic [31:0]       zz32;
  logic [ValueW-1:0] zz64;

  assign out_valid_o = (cnt_q != '0);
  assign out_byte_o  = buf_q[ByteW-1:0];
  assign last_o      = (cnt_q == CntW'(1));
  assign out_take    = out_valid_o && out_ready_i;
  assign load        = in_valid_q && ((cnt_q == '0) || (last_o && out_ready_i));
  assign in_ready_o  = !in_valid_q || load;

  always_comb begin
    tc         = type_code(type_sel_q);
    delta      = {field_id_q[IdW-1], field_id_q} - {prev_id_q[IdW-1], prev_id_q};
    fld_short  = !delta[IdW] && (delta[IdW-1:4] == '0) && (delta[3:0] != 4'd0);
    list_short = (list_size_q[SizeW-1:4] == '0) && (list_size_q[3:0] <= ShortListMax);
    zz16       = {field_id_q[IdW-2:0], 1'b0} ^ {IdW{field_id_q[IdW-1]}};
    zz32       = {value_q[30:0], 1'b0} ^ {32{value_q[31]}};
    zz64       = {value_q[ValueW-2:0], 1'b0} ^ {ValueW{value_q[ValueW-1]}};
  end

  // varint of the selected operand
  always_comb begin
    unique case (cmd_q)
      CmdField: vsrc = {{(ValueW-IdW){1'b0}}, zz16};
      CmdList:  vsrc = {{(ValueW-SizeW){1'b0}}, list_size_q};
      CmdI32:   vsrc = {32'd0, zz32};
      CmdI64:   vsrc = zz64;
      default:  vsrc = value_q;
    endcase
    vext = {6'd0, vsrc};
    vcnt = CntW'(1);
    for (int i = 0; i < MaxBytes; i++) begin
      grp[i] = vext[GroupW*i +: GroupW];
      if (grp[i] != '0) vcnt = CntW'(i + 1);
    end
    for (int i = 0; i < MaxBytes; i++) begin
      vbytes[ByteW*i +: ByteW] = {(CntW'(i + 1) < vcnt), grp[i]};
    end
  end

  always_comb begin
    enc_bytes = '0;
    enc_cnt   = CntW'(1);
    unique case (cmd_q)
      CmdRaw: begin
        enc_bytes[ByteW-1:0] = value_q[ByteW-1:0];
      end
      CmdBool: begin
        enc_bytes[ByteW-1:0] = (value_q != '0) ? BoolTrue : BoolFalse;
      end
      CmdShortFld: begin
        enc_bytes[ByteW-1:0] = ShortField | {4'd0, tc};
      end
      CmdField: begin
        if (fld_short) begin
          enc_bytes[ByteW-1:0] = {delta[3:0], tc};
        end else begin
          enc_bytes = {vbytes[BufW-ByteW-1:0], 4'd0, tc};
          enc_cnt   = CntW'(vcnt + CntW'(1));
        end
      end
      CmdList: begin
        if (list_short) begin
          enc_bytes[ByteW-1:0] = {list_size_q[3:0], tc};
        end else begin
          enc_bytes = {vbytes[BufW-ByteW-1:0], LongList | {4'd0, tc}};
          enc_cnt   = CntW'(vcnt + CntW'(1));
        end
      end
      CmdI16: begin
        enc_bytes[2*ByteW-1:0] = {value_q[7:0], value_q[15:8]};
        enc_cnt = CntW'(2);
      end
      CmdI32, CmdI64, CmdUvarint: begin
        enc_bytes = vbytes;
        enc_cnt   = vcnt;
      end
      default: begin
        enc_cnt = '0;
      end
    endcase
  end

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (load) begin
      buf_d = enc_bytes;
      cnt_d = enc_cnt;
    end else if (out_take) begin
      buf_d = {{ByteW{1'b0}}, buf_q[BufW-1:ByteW]};
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q       <= cmd_i;
      type_sel_q  <= type_sel_i;
      field_id_q  <= field_id_i;
      prev_id_q   <= prev_id_i;
      list_size_q <= list_size_i;
      value_q     <= value_i;
    end
    buf_q <= buf_d;
  end

  // a byte taken that is not the last leaves more bytes behind
  `TCTE_ASSERT(a_more_bytes, (out_take && !last_o) |=> out_valid_o)
  // a request held in the input register is not overwritten
  `TCTE_ASSERT(a_hold_req, (in_valid_q && !in_ready_o) |=> (in_valid_q && $stable(cmd_q)))
  // byte count never exceeds the longest encoding
  `TCTE_ASSERT_ALWAYS(a_cnt_range, cnt_q <= CntW'(MaxBytes))

endmodule
